// File: rtl/lcgur_pkg.sv
// ============================================================================
// lcgur_pkg
// Types and constants shared by the uniform range generator modules.
// ============================================================================
package lcgur_pkg;

    localparam int WORD_W  = 64;
    localparam int STATE_W = 2 * WORD_W;
    localparam int DIGIT_W = 8;
    localparam int MUL_STEPS = STATE_W / DIGIT_W;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [STATE_W-1:0] state_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    // Generator multiplier, high word then low word.
    localparam word_t  MUL_HI_WORD = 64'd1360472147205615982;
    localparam word_t  MUL_LO_WORD = 64'd3346542527535191717;
    localparam state_t MUL_A       = {MUL_HI_WORD, MUL_LO_WORD};

endpackage

// File: rtl/lcgur_mul.sv
// ============================================================================
// lcgur_mul
// Digit-serial multiplier: product = state * A mod 2^128, one byte a cycle.
// ============================================================================
module lcgur_mul
    import lcgur_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  state_t state_in,
    output logic   done,
    output state_t product
);

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    state_t             shift_reg, shift_next;
    state_t             acc_reg, acc_next;
    digit_t             digit;
    state_t             partial;

    // Horner form from the most significant digit down; bits above 2^128 fall away.
    assign digit   = shift_reg[STATE_W-1 -: DIGIT_W];
    assign partial = state_t'(MUL_A * state_t'(digit));

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = state_in;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            acc_next   = (acc_reg << DIGIT_W) + partial;
            shift_next = shift_reg << DIGIT_W;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        acc_reg   <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// File: rtl/lcgur_rem.sv
// ============================================================================
// lcgur_rem
// Bit-serial restoring remainder unit: 64-bit dividend modulo a 64-bit divisor.
// ============================================================================
module lcgur_rem
    import lcgur_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  done,
    output word_t remainder
);

    localparam int CNT_W = $clog2(WORD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            dvd_reg, dvd_next;
    word_t            dvs_reg, dvs_next;
    word_t            rem_reg, rem_next;
    logic [WORD_W:0]  trial;
    logic [WORD_W:0]  diff;

    // The partial remainder stays below the divisor, so one subtract a bit suffices.
    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (diff[WORD_W])
                rem_next = trial[WORD_W-1:0];
            else
                rem_next = diff[WORD_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/lcg128_uniform_range.sv
// ============================================================================
// lcg128_uniform_range
// Uniform signed integers in a range from a 128-bit multiplicative LCG.
// ============================================================================
//
//  Channel   Handshake             Payload
//  -------   -------------------   --------------------------------
//  request   in_valid / in_ready   min_value, max_value (signed 64)
//  result    out_valid / out_ready value (signed 64)
//  config    seed_we               seed (unsigned 64)
//
//  A request with min_value >= max_value skips the arithmetic and goes through
//  ST_DONE to the output register. Any other request runs the byte-serial
//  128-bit state multiply, then the bit-serial remainder, then the hand-over.
//  The full signed range skips the remainder.
//  One request is in work at a time; a new one is taken while the previous result
//  still waits in the output register. Reset leaves state_high at zero, state_low at one.
//
module lcg128_uniform_range
    import lcgur_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seed_we,
    input  logic [63:0]        seed,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [63:0] min_value,
    input  logic signed [63:0] max_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] value
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] st_reg, st_next;
    word_t      state_high_reg, state_high_next;
    word_t      state_low_reg, state_low_next;
    word_t      min_reg, min_next;
    word_t      span_reg, span_next;
    word_t      res_reg, res_next;
    logic       out_valid_reg, out_valid_next;
    word_t      value_reg, value_next;

    logic       accept;
    logic       empty_range;
    logic       mul_start;
    logic       mul_done;
    state_t     product;
    logic       rem_start;
    logic       rem_done;
    word_t      remainder;
    word_t      req_span;

    assign accept      = in_valid && in_ready;
    assign empty_range = (min_value >= max_value);
    assign req_span    = word_t'(max_value) - word_t'(min_value) + word_t'(1);
    assign mul_start   = accept && !empty_range;
    // A zero span can only come from the full signed range.
    assign rem_start   = (st_reg == ST_MUL) && mul_done && (span_reg != '0);

    lcgur_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .state_in ({state_high_reg, state_low_reg}),
        .done     (mul_done),
        .product  (product)
    );

    lcgur_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (product[STATE_W-1:WORD_W]),
        .divisor   (span_reg),
        .done      (rem_done),
        .remainder (remainder)
    );

    always_comb
    begin
        st_next         = st_reg;
        state_high_next = state_high_reg;
        state_low_next  = state_low_reg;
        min_next        = min_reg;
        span_next       = span_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        value_next      = value_reg;

        if (seed_we)
            state_low_next = {seed[WORD_W-2:0], 1'b1};

        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    min_next  = word_t'(min_value);
                    span_next = req_span;
                    if (empty_range)
                    begin
                        res_next = word_t'(min_value);
                        st_next  = ST_DONE;
                    end
                    else
                    begin
                        st_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_high_next = product[STATE_W-1:WORD_W];
                    state_low_next  = product[WORD_W-1:0];
                    if (span_reg == '0)
                    begin
                        res_next = product[STATE_W-1:WORD_W];
                        st_next  = ST_DONE;
                    end
                    else
                    begin
                        st_next = ST_REM;
                    end
                end
            end
            ST_REM:
            begin
                if (rem_done)
                begin
                    res_next = remainder + min_reg;
                    st_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    value_next     = res_reg;
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            state_high_reg <= '0;
            state_low_reg  <= word_t'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            state_high_reg <= state_high_next;
            state_low_reg  <= state_low_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg   <= min_next;
        span_reg  <= span_next;
        res_reg   <= res_next;
        value_reg <= value_next;
    end

    assign in_ready  = (st_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule
